// ===== design/twm_pkg.sv =====
package twm_pkg;

  // Defaults for the top-level parameters
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TIME_BITS_DEF   = 48;

  // Fixed field widths
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 16;
  localparam int WINDOW_W = 16;

  // Results one input may cause before the merge pauses
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd50;

  // Input action codes
  localparam logic [ACTION_W-1:0] ACT_POSE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_DETECT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

  // Result kind codes
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_DROP  = 1'b1;

  // Commands passed from front to back
  typedef enum logic [1:0] {
    CMD_POSE,
    CMD_DETECT,
    CMD_CLEAR
  } cmd_kind_t;

endpackage

// ===== design/twm_in_if.sv =====
interface twm_in_if
  import twm_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [TIME_BITS-1:0] frame_time;

  modport source (output valid, action, frame_time, input ready);
  modport sink   (input valid, action, frame_time, output ready);
endinterface

// ===== design/twm_out_if.sv =====
interface twm_out_if
  import twm_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [INDEX_W-1:0]          pose_index;
  logic [INDEX_W-1:0]          detect_index;
  logic [TIME_BITS-1:0]        pose_time;
  logic [TIME_BITS-1:0]        detect_time;
  logic signed [TIME_BITS:0]   time_diff;
  logic                        last;

  modport source (output valid, kind, pose_index, detect_index, pose_time, detect_time,
                  time_diff, last, input ready);
  modport sink   (input valid, kind, pose_index, detect_index, pose_time, detect_time,
                  time_diff, last, output ready);
endinterface

// ===== design/twm_front.sv =====
module twm_front
  import twm_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  twm_in_if.sink               in_ch,
  output logic                 cmd_valid,
  output cmd_kind_t            cmd_kind,
  output logic [TIME_BITS-1:0] cmd_ts,
  input  logic                 cmd_pop
);

  // two-entry command queue
  localparam int CQ_DEPTH = 2;

  cmd_kind_t            kind_mem [CQ_DEPTH];
  logic [TIME_BITS-1:0] ts_mem   [CQ_DEPTH];
  logic                 wr_ptr_r, wr_ptr_nxt;
  logic                 rd_ptr_r, rd_ptr_nxt;
  logic [1:0]           count_r, count_nxt;
  logic                 accept;
  logic                 push;
  logic                 pop;
  cmd_kind_t            kind_cls;

  assign in_ch.ready = (count_r != 2'(CQ_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  // classify; unused action is taken and dropped
  always_comb begin
    kind_cls = CMD_CLEAR;
    push     = 1'b0;
    unique case (in_ch.action)
      ACT_POSE: begin
        kind_cls = CMD_POSE;
        push     = accept;
      end
      ACT_DETECT: begin
        kind_cls = CMD_DETECT;
        push     = accept;
      end
      ACT_CLEAR: begin
        kind_cls = CMD_CLEAR;
        push     = accept;
      end
      ACT_NONE: begin
        push = 1'b0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign cmd_valid = (count_r != 2'd0);
  assign cmd_kind  = kind_mem[rd_ptr_r];
  assign cmd_ts    = ts_mem[rd_ptr_r];
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind_mem[wr_ptr_r] <= kind_cls;
      ts_mem[wr_ptr_r]   <= in_ch.frame_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== design/twm_back.sv =====
module twm_back
  import twm_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [WINDOW_W-1:0]  window,
  input  logic                 cmd_valid,
  input  cmd_kind_t            cmd_kind,
  input  logic [TIME_BITS-1:0] cmd_ts,
  output logic                 cmd_pop,
  twm_out_if.source            out_ch
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int DIFF_W = TIME_BITS + 1;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RD,
    B_DIFF,
    B_CMP
  } state_t;

  // sample queues
  logic [TIME_BITS-1:0] pose_time_mem [QUEUE_DEPTH];
  logic [INDEX_W-1:0]   pose_idx_mem  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] det_time_mem  [QUEUE_DEPTH];
  logic [INDEX_W-1:0]   det_idx_mem   [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] pose_rd_time_r, det_rd_time_r;
  logic [INDEX_W-1:0]   pose_rd_idx_r, det_rd_idx_r;
  logic                 pose_we, det_we;
  logic [PTR_W-1:0]     pose_wr_addr, det_wr_addr;
  logic [FILL_W:0]      pose_sum, det_sum, pose_slot, det_slot;

  state_t               state_r, state_nxt;
  logic [FILL_W-1:0]    pose_fill_r, pose_fill_nxt, det_fill_r, det_fill_nxt;
  logic [PTR_W-1:0]     pose_head_r, pose_head_nxt, det_head_r, det_head_nxt;
  logic [INDEX_W-1:0]   pose_cnt_r, pose_cnt_nxt, det_cnt_r, det_cnt_nxt;
  logic [RES_CNT_W-1:0] nres_r, nres_nxt;
  logic signed [DIFF_W-1:0] diff_r, diff_nxt;

  // held result: its last flag is known only once the next one appears
  logic                 pend_v_r, pend_v_nxt;
  logic                 pend_kind_r, pend_kind_nxt;
  logic [INDEX_W-1:0]   pend_pidx_r, pend_pidx_nxt, pend_didx_r, pend_didx_nxt;
  logic [TIME_BITS-1:0] pend_pt_r, pend_pt_nxt, pend_dt_r, pend_dt_nxt;
  logic signed [DIFF_W-1:0] pend_diff_r, pend_diff_nxt;

  // output register
  logic                 out_v_r, out_v_nxt;
  logic                 out_kind_r, out_kind_nxt;
  logic [INDEX_W-1:0]   out_pidx_r, out_pidx_nxt, out_didx_r, out_didx_nxt;
  logic [TIME_BITS-1:0] out_pt_r, out_pt_nxt, out_dt_r, out_dt_nxt;
  logic signed [DIFF_W-1:0] out_diff_r, out_diff_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 out_free;
  logic                 in_window;
  logic signed [DIFF_W-1:0] pos_w, neg_w;
  logic [PTR_W-1:0]     pose_head_inc, det_head_inc;

  assign out_free = !out_v_r || out_ch.ready;

  // ring write slot = head + fill, wrapped
  always_comb begin
    pose_sum  = (FILL_W+1)'(pose_head_r) + (FILL_W+1)'(pose_fill_r);
    det_sum   = (FILL_W+1)'(det_head_r) + (FILL_W+1)'(det_fill_r);
    pose_slot = (pose_sum >= (FILL_W+1)'(QUEUE_DEPTH)) ?
                pose_sum - (FILL_W+1)'(QUEUE_DEPTH) : pose_sum;
    det_slot  = (det_sum >= (FILL_W+1)'(QUEUE_DEPTH)) ?
                det_sum - (FILL_W+1)'(QUEUE_DEPTH) : det_sum;
  end
  assign pose_wr_addr = pose_slot[PTR_W-1:0];
  assign det_wr_addr  = det_slot[PTR_W-1:0];

  assign pose_head_inc = (pose_head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : pose_head_r + 1'b1;
  assign det_head_inc  = (det_head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : det_head_r + 1'b1;

  // |diff| < window, split on sign
  assign pos_w     = signed'({{(DIFF_W - WINDOW_W){1'b0}}, window});
  assign neg_w     = -pos_w;
  assign in_window = diff_r[DIFF_W-1] ? (diff_r > neg_w) : (diff_r < pos_w);

  always_ff @(posedge clk) begin
    if (pose_we) begin
      pose_time_mem[pose_wr_addr] <= cmd_ts;
      pose_idx_mem[pose_wr_addr]  <= pose_cnt_r;
    end
    if (det_we) begin
      det_time_mem[det_wr_addr] <= cmd_ts;
      det_idx_mem[det_wr_addr]  <= det_cnt_r;
    end
    pose_rd_time_r <= pose_time_mem[pose_head_r];
    pose_rd_idx_r  <= pose_idx_mem[pose_head_r];
    det_rd_time_r  <= det_time_mem[det_head_r];
    det_rd_idx_r   <= det_idx_mem[det_head_r];
  end

  always_comb begin
    state_nxt     = state_r;
    pose_fill_nxt = pose_fill_r;
    det_fill_nxt  = det_fill_r;
    pose_head_nxt = pose_head_r;
    det_head_nxt  = det_head_r;
    pose_cnt_nxt  = pose_cnt_r;
    det_cnt_nxt   = det_cnt_r;
    nres_nxt      = nres_r;
    diff_nxt      = diff_r;
    pend_v_nxt    = pend_v_r;
    pend_kind_nxt = pend_kind_r;
    pend_pidx_nxt = pend_pidx_r;
    pend_didx_nxt = pend_didx_r;
    pend_pt_nxt   = pend_pt_r;
    pend_dt_nxt   = pend_dt_r;
    pend_diff_nxt = pend_diff_r;
    out_v_nxt     = out_ch.ready ? 1'b0 : out_v_r;
    out_kind_nxt  = out_kind_r;
    out_pidx_nxt  = out_pidx_r;
    out_didx_nxt  = out_didx_r;
    out_pt_nxt    = out_pt_r;
    out_dt_nxt    = out_dt_r;
    out_diff_nxt  = out_diff_r;
    out_last_nxt  = out_last_r;
    cmd_pop       = 1'b0;
    pose_we       = 1'b0;
    det_we        = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          nres_nxt = '0;
          unique case (cmd_kind)
            CMD_CLEAR: begin
              pose_fill_nxt = '0;
              det_fill_nxt  = '0;
              pose_head_nxt = '0;
              det_head_nxt  = '0;
              pose_cnt_nxt  = '0;
              det_cnt_nxt   = '0;
            end
            CMD_POSE: begin
              if (pose_fill_r == FILL_W'(QUEUE_DEPTH)) begin
                pend_v_nxt    = 1'b1;
                pend_kind_nxt = KIND_DROP;
                pend_pidx_nxt = pose_cnt_r;
                pend_didx_nxt = '0;
                pend_pt_nxt   = cmd_ts;
                pend_dt_nxt   = '0;
                pend_diff_nxt = '0;
                nres_nxt      = RES_CNT_W'(1);
              end else begin
                pose_we       = 1'b1;
                pose_fill_nxt = pose_fill_r + 1'b1;
              end
              pose_cnt_nxt = pose_cnt_r + 1'b1;
              state_nxt    = B_RD;
            end
            CMD_DETECT: begin
              if (det_fill_r == FILL_W'(QUEUE_DEPTH)) begin
                pend_v_nxt    = 1'b1;
                pend_kind_nxt = KIND_DROP;
                pend_pidx_nxt = '0;
                pend_didx_nxt = det_cnt_r;
                pend_pt_nxt   = '0;
                pend_dt_nxt   = cmd_ts;
                pend_diff_nxt = '0;
                nres_nxt      = RES_CNT_W'(1);
              end else begin
                det_we       = 1'b1;
                det_fill_nxt = det_fill_r + 1'b1;
              end
              det_cnt_nxt = det_cnt_r + 1'b1;
              state_nxt   = B_RD;
            end
            default: begin
              state_nxt = B_IDLE;
            end
          endcase
        end
      end

      B_RD: begin
        if ((pose_fill_r != '0) && (det_fill_r != '0) &&
            (nres_r < RES_CNT_W'(MAX_RESULTS))) begin
          state_nxt = B_DIFF;
        end else if (pend_v_r) begin
          if (out_free) begin
            out_v_nxt    = 1'b1;
            out_kind_nxt = pend_kind_r;
            out_pidx_nxt = pend_pidx_r;
            out_didx_nxt = pend_didx_r;
            out_pt_nxt   = pend_pt_r;
            out_dt_nxt   = pend_dt_r;
            out_diff_nxt = pend_diff_r;
            out_last_nxt = 1'b1;
            pend_v_nxt   = 1'b0;
            state_nxt    = B_IDLE;
          end
        end else begin
          state_nxt = B_IDLE;
        end
      end

      B_DIFF: begin
        diff_nxt  = signed'({1'b0, pose_rd_time_r}) - signed'({1'b0, det_rd_time_r});
        state_nxt = B_CMP;
      end

      B_CMP: begin
        if (in_window) begin
          if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_v_nxt    = 1'b1;
              out_kind_nxt = pend_kind_r;
              out_pidx_nxt = pend_pidx_r;
              out_didx_nxt = pend_didx_r;
              out_pt_nxt   = pend_pt_r;
              out_dt_nxt   = pend_dt_r;
              out_diff_nxt = pend_diff_r;
              out_last_nxt = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_kind_nxt = KIND_MATCH;
            pend_pidx_nxt = pose_rd_idx_r;
            pend_didx_nxt = det_rd_idx_r;
            pend_pt_nxt   = pose_rd_time_r;
            pend_dt_nxt   = det_rd_time_r;
            pend_diff_nxt = diff_r;
            nres_nxt      = nres_r + 1'b1;
            det_head_nxt  = det_head_inc;
            det_fill_nxt  = det_fill_r - 1'b1;
            state_nxt     = B_RD;
          end
        end else if (diff_r[DIFF_W-1]) begin
          pose_head_nxt = pose_head_inc;
          pose_fill_nxt = pose_fill_r - 1'b1;
          state_nxt     = B_RD;
        end else begin
          det_head_nxt = det_head_inc;
          det_fill_nxt = det_fill_r - 1'b1;
          state_nxt    = B_RD;
        end
      end

      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    diff_r      <= diff_nxt;
    nres_r      <= nres_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_pidx_r <= pend_pidx_nxt;
    pend_didx_r <= pend_didx_nxt;
    pend_pt_r   <= pend_pt_nxt;
    pend_dt_r   <= pend_dt_nxt;
    pend_diff_r <= pend_diff_nxt;
    out_kind_r  <= out_kind_nxt;
    out_pidx_r  <= out_pidx_nxt;
    out_didx_r  <= out_didx_nxt;
    out_pt_r    <= out_pt_nxt;
    out_dt_r    <= out_dt_nxt;
    out_diff_r  <= out_diff_nxt;
    out_last_r  <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= B_IDLE;
      pose_fill_r <= '0;
      det_fill_r  <= '0;
      pose_head_r <= '0;
      det_head_r  <= '0;
      pose_cnt_r  <= '0;
      det_cnt_r   <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pose_fill_r <= pose_fill_nxt;
      det_fill_r  <= det_fill_nxt;
      pose_head_r <= pose_head_nxt;
      det_head_r  <= det_head_nxt;
      pose_cnt_r  <= pose_cnt_nxt;
      det_cnt_r   <= det_cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.pose_index   = out_pidx_r;
  assign out_ch.detect_index = out_didx_r;
  assign out_ch.pose_time    = out_pt_r;
  assign out_ch.detect_time  = out_dt_r;
  assign out_ch.time_diff    = out_diff_r;
  assign out_ch.last         = out_last_r;

endmodule

// ===== design/timestamp_window_match_top.sv =====
// Timestamp window matcher: aligns a sorted pose timestamp stream with a sorted
// detector timestamp stream. Each in_ch word carries an action (push pose, push
// detector, clear, or no-op) and a timestamp. Pushed frames get a 16-bit sequence
// number and go into a ring queue of QUEUE_DEPTH entries per side; a push into a
// full queue yields one "dropped" result word. After every push the queue heads
// are compared: |pose - detect| < match_window gives a match word and retires the
// detector head, otherwise the older head is retired. The last word caused by one
// input has last = 1; clear and no-op give no words. Flow: a front stage takes
// words into a two-entry command queue, so in_ch keeps taking words while the
// merge engine works, until that queue is full. A push runs a queue read,
// subtract and window check for each head compare, and the engine waits while
// out_ch holds back ready. match_window (reset 50) is written through cfg_wr_en /
// cfg_wr_data and must only change while the block is idle.
module timestamp_window_match_top
  import twm_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  twm_in_if.sink              in_ch,
  twm_out_if.source           out_ch,
  input  logic                cfg_wr_en,
  input  logic [WINDOW_W-1:0] cfg_wr_data
);

  // match window register
  logic [WINDOW_W-1:0] window_r, window_nxt;

  // front -> back command
  logic                 cmd_valid;
  cmd_kind_t            cmd_kind;
  logic [TIME_BITS-1:0] cmd_ts;
  logic                 cmd_pop;

  assign window_nxt = cfg_wr_en ? cfg_wr_data : window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  // accept and classify
  twm_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_kind  (cmd_kind),
    .cmd_ts    (cmd_ts),
    .cmd_pop   (cmd_pop)
  );

  // queues and merge engine
  twm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .window    (window_r),
    .cmd_valid (cmd_valid),
    .cmd_kind  (cmd_kind),
    .cmd_ts    (cmd_ts),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/sv/timestamp_window_match_top_test.sv =====
`timescale 1ns / 100ps

module timestamp_window_match_top_test;
  import twm_pkg::*;

  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int TBITS       = TIME_BITS_DEF;
  localparam int LONG_HOLD   = 400;   // receiver hold-off used to back the block up
  localparam int SETTLE      = 300;   // worst push chain plus two queued commands
  localparam int STALL_LIMIT = 4000;  // cycles with no word moving on either side

  typedef logic [TBITS-1:0] stamp_t;

  localparam stamp_t TS_MAX   = '1;
  localparam stamp_t HEADROOM = stamp_t'(1) << 25;  // keeps a stream from wrapping

  typedef struct packed {
    logic                  kind;
    logic [INDEX_W-1:0]    pose_index;
    logic [INDEX_W-1:0]    detect_index;
    stamp_t                pose_time;
    stamp_t                detect_time;
    logic signed [TBITS:0] time_diff;
    logic                  last;
  } match_word_t;

  // Per accepted input word: use the hand-written result instead of the predictor's.
  typedef struct packed {
    logic        typed;
    match_word_t word;
  } word_hint_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    stamp_t              stamp;
    logic [7:0]          reps;   // stamp steps by one per repeat
    logic                typed;
    match_word_t         word;
  } stim_row_t;

  // Directed rows, run at the reset window of 50.
  localparam stim_row_t DIRECTED_ROWS [11] = '{
    '{ACT_POSE,   48'd0,    8'd1,  1'b0, '0},
    // equal stamps match
    '{ACT_DETECT, 48'd0,    8'd1,  1'b1,
      '{KIND_MATCH, 16'd0, 16'd0, 48'd0, 48'd0, 49'sd0, 1'b1}},
    // just inside the window, negative diff
    '{ACT_DETECT, 48'd49,   8'd1,  1'b1,
      '{KIND_MATCH, 16'd0, 16'd1, 48'd0, 48'd49, -49'sd49, 1'b1}},
    // diff equal to window: no match, older pose head retired
    '{ACT_DETECT, 48'd50,   8'd1,  1'b0, '0},
    // top stamp retires the detector head
    '{ACT_POSE,   TS_MAX,   8'd1,  1'b0, '0},
    '{ACT_DETECT, TS_MAX,   8'd1,  1'b1,
      '{KIND_MATCH, 16'd1, 16'd3, TS_MAX, TS_MAX, 49'sd0, 1'b1}},
    '{ACT_NONE,   TS_MAX,   8'd1,  1'b0, '0},
    '{ACT_CLEAR,  TS_MAX,   8'd1,  1'b0, '0},
    // fill the pose queue, then overflow it
    '{ACT_POSE,   48'd1000, 8'd16, 1'b0, '0},
    '{ACT_POSE,   48'd1016, 8'd1,  1'b1,
      '{KIND_DROP, 16'd16, 16'd0, 48'd1016, 48'd0, 49'sd0, 1'b1}},
    '{ACT_DETECT, 48'd1001, 8'd1,  1'b1,
      '{KIND_MATCH, 16'd0, 16'd0, 48'd1000, 48'd1001, -49'sd1, 1'b1}}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [WINDOW_W-1:0] cfg_wr_data;

  twm_in_if  #(.TIME_BITS(TBITS)) in_ch ();
  twm_out_if #(.TIME_BITS(TBITS)) out_ch ();

  timestamp_window_match_top #(
    .QUEUE_DEPTH(DEPTH),
    .TIME_BITS  (TBITS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Predictor state: two ring queues of stamps and sequence numbers.
  stamp_t              pose_ts_mem   [DEPTH];
  logic [INDEX_W-1:0]  pose_seq_mem  [DEPTH];
  stamp_t              detect_ts_mem [DEPTH];
  logic [INDEX_W-1:0]  detect_seq_mem[DEPTH];
  int unsigned         pose_fill   = 0;
  int unsigned         detect_fill = 0;
  int unsigned         pose_head   = 0;
  int unsigned         detect_head = 0;
  logic [INDEX_W-1:0]  pose_seq    = '0;
  logic [INDEX_W-1:0]  detect_seq  = '0;
  logic [WINDOW_W-1:0] window_setting;

  match_word_t predicted_words[$];   // results of the word just accepted
  match_word_t expected_words[$];    // results still owed by the block
  word_hint_t  word_hints[$];        // one per word offered, in order

  int     fail_count    = 0;
  int     quiet_cycles  = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_requests = 0;
  int     hold_served   = 0;
  stamp_t stream_time;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Two-pointer merge on the queue heads after every push.
  function automatic void predict_merge(input logic [ACTION_W-1:0] act, input stamp_t ts);
    stamp_t      p;
    stamp_t      d;
    stamp_t      mag;
    match_word_t w;
    predicted_words.delete();
    if (act == ACT_CLEAR) begin
      // only fills, heads and counters reset; queue contents stay
      pose_fill   = 0;
      detect_fill = 0;
      pose_head   = 0;
      detect_head = 0;
      pose_seq    = '0;
      detect_seq  = '0;
    end else if (act == ACT_POSE || act == ACT_DETECT) begin
      if (act == ACT_POSE) begin
        if (pose_fill >= DEPTH) begin
          w            = '0;
          w.kind       = KIND_DROP;
          w.pose_index = pose_seq;
          w.pose_time  = ts;
          predicted_words.insert(predicted_words.size(), w);
        end else begin
          pose_ts_mem[(pose_head + pose_fill) % DEPTH]  = ts;
          pose_seq_mem[(pose_head + pose_fill) % DEPTH] = pose_seq;
          pose_fill++;
        end
        pose_seq++;   // a dropped frame still uses up its number
      end else begin
        if (detect_fill >= DEPTH) begin
          w              = '0;
          w.kind         = KIND_DROP;
          w.detect_index = detect_seq;
          w.detect_time  = ts;
          predicted_words.insert(predicted_words.size(), w);
        end else begin
          detect_ts_mem[(detect_head + detect_fill) % DEPTH]  = ts;
          detect_seq_mem[(detect_head + detect_fill) % DEPTH] = detect_seq;
          detect_fill++;
        end
        detect_seq++;
      end
      while (pose_fill > 0 && detect_fill > 0 && predicted_words.size() < MAX_RESULTS) begin
        p   = pose_ts_mem[pose_head];
        d   = detect_ts_mem[detect_head];
        mag = (p >= d) ? p - d : d - p;
        if (mag < stamp_t'(window_setting)) begin
          w              = '0;
          w.kind         = KIND_MATCH;
          w.pose_index   = pose_seq_mem[pose_head];
          w.detect_index = detect_seq_mem[detect_head];
          w.pose_time    = p;
          w.detect_time  = d;
          w.time_diff    = {1'b0, p} - {1'b0, d};
          predicted_words.insert(predicted_words.size(), w);
          detect_head = (detect_head + 1) % DEPTH;
          detect_fill--;
        end else if (p < d) begin
          pose_head = (pose_head + 1) % DEPTH;
          pose_fill--;
        end else begin
          detect_head = (detect_head + 1) % DEPTH;
          detect_fill--;
        end
      end
      if (predicted_words.size() > 0) begin
        w      = predicted_words.pop_back();
        w.last = 1'b1;
        predicted_words.insert(predicted_words.size(), w);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want_v,
                                      input logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  function automatic stamp_t random_stamp();
    return stamp_t'({$urandom, $urandom});
  endfunction

  // New start for the sorted streams, anywhere in the stamp range that leaves HEADROOM below the top.
  function automatic stamp_t fresh_base();
    stamp_t b;
    b = random_stamp();
    if (b > TS_MAX - HEADROOM) b -= HEADROOM;
    return b;
  endfunction

  // Jitter scale tied to the window so that roughly half the pairs match.
  function automatic int unsigned jitter_span();
    return (window_setting == 0) ? 3 : window_setting;
  endfunction

  // Scoreboard: results checked before predicting the word taken at the same edge.
  always @(posedge clk) begin : scoreboard
    match_word_t want;
    word_hint_t  hint;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no expectation pending");
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("pose_index", want.pose_index, out_ch.pose_index);
          check_field("detect_index", want.detect_index, out_ch.detect_index);
          check_field("pose_time", want.pose_time, out_ch.pose_time);
          check_field("detect_time", want.detect_time, out_ch.detect_time);
          check_field("time_diff", $signed(want.time_diff), $signed(out_ch.time_diff));
          check_field("last", want.last, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        hint = word_hints.pop_front();
        predict_merge(in_ch.action, in_ch.frame_time);   // state moves either way
        if (hint.typed) begin
          expected_words.insert(expected_words.size(), hint.word);
        end else begin
          foreach (predicted_words[k]) begin
            expected_words.insert(expected_words.size(), predicted_words[k]);
          end
        end
      end
    end
    // watchdog: nothing moving on either channel for too long
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side: random stalls, or one long hold-off counted here when asked for.
  initial begin : result_sink
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_served++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one word after random idle cycles; returns at the accepting edge.
  task automatic send_word(input logic [ACTION_W-1:0] act, input stamp_t ts,
                           input logic typed, input match_word_t word);
    word_hint_t hint;
    hint.typed = typed;
    hint.word  = word;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    word_hints.insert(word_hints.size(), hint);
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.frame_time <= ts;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Several pushes on one side in rising order; long runs overflow the queue.
  task automatic send_run(input logic [ACTION_W-1:0] side, input int n);
    int unsigned span;
    span = jitter_span();
    repeat (n) begin
      send_word(side, stream_time, 1'b0, '0);
      stream_time += stamp_t'($urandom_range(span, 1));
    end
  endtask

  // Mostly sorted pose/detector pairs near a common time, plus runs and noise.
  task automatic send_random_items(input int count);
    int          done;
    int          n;
    int unsigned pick;
    int unsigned span;
    stamp_t      tp;
    stamp_t      td;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      span = jitter_span();
      if (pick < 3) begin
        send_word(ACT_CLEAR, random_stamp(), 1'b0, '0);
        stream_time = fresh_base();
        done++;
      end else if (pick < 6) begin
        // no-op word: ignored, not counted
        send_word(ACT_NONE, random_stamp(), 1'b0, '0);
      end else if (pick < 11) begin
        // out-of-order stamp anywhere in range
        send_word($urandom_range(1) ? ACT_POSE : ACT_DETECT, random_stamp(), 1'b0, '0);
        done++;
      end else if (pick < 16) begin
        n = $urandom_range(6, 2);
        send_run($urandom_range(1) ? ACT_POSE : ACT_DETECT, n);
        done += n;
      end else begin
        tp = stream_time + stamp_t'($urandom_range(span));
        td = stream_time + stamp_t'($urandom_range(span));
        case ($urandom_range(9))
          0: begin
            send_word(ACT_POSE, tp, 1'b0, '0);
            done++;
          end
          1: begin
            send_word(ACT_DETECT, td, 1'b0, '0);
            done++;
          end
          default: begin
            if ($urandom_range(1)) begin
              send_word(ACT_POSE, tp, 1'b0, '0);
              send_word(ACT_DETECT, td, 1'b0, '0);
            end else begin
              send_word(ACT_DETECT, td, 1'b0, '0);
              send_word(ACT_POSE, tp, 1'b0, '0);
            end
            done += 2;
          end
        endcase
        stream_time += stamp_t'(2 * span + $urandom_range(16, 1));
      end
    end
  endtask

  // Wait for every owed result, then let pushes with no result finish.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_match_window(input logic [WINDOW_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en      <= 1'b0;
    window_setting = value;
  endtask

  initial begin : stimulus
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_NONE;
    in_ch.frame_time = '0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    window_setting   = WINDOW_RESET;
    stream_time      = fresh_base();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at the reset window, no idling
    foreach (DIRECTED_ROWS[i]) begin
      for (int r = 0; r < DIRECTED_ROWS[i].reps; r++) begin
        send_word(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].stamp + stamp_t'(r),
                  DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].word);
      end
    end
    drain_results();

    // widest window, no idling; opens with a detector overflow
    write_match_window(16'hFFFF);
    send_word(ACT_CLEAR, random_stamp(), 1'b0, '0);
    send_run(ACT_DETECT, DEPTH + 2);
    send_random_items(10);
    drain_results();

    // narrowest window (exact match only), sparse sender
    send_idle_pct = 88;
    write_match_window(16'd1);
    send_random_items(18);
    drain_results();

    // zero window never matches; receiver mostly stalled
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    write_match_window(16'd0);
    send_random_items(18);
    drain_results();

    // mid window, light idling both sides; long hold-off fills the block
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    write_match_window(16'($urandom_range(65534, 2)));
    hold_requests++;
    send_random_items(18);
    drain_results();

    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/twm_pkg.sv
design/twm_in_if.sv
design/twm_out_if.sv
design/twm_front.sv
design/twm_back.sv
design/timestamp_window_match_top.sv
tb/sv/timestamp_window_match_top_test.sv
